// File: rtl/frcr_pkg.sv
// Shared types, constants and helpers for the regulated clock reference.
package frcr_pkg;

  localparam int unsigned PTS_W     = 48;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned SPEED_W   = 5;
  localparam int unsigned BLOCKS_W  = 16;
  localparam int unsigned TUNE_W    = 2;
  localparam int unsigned RATE_W    = 29;
  localparam int unsigned FRAC_W    = 30;
  localparam int unsigned PROD_W    = RATE_W + ELAPSED_W;   // 49
  localparam int unsigned TOTAL_W   = PROD_W + 1;           // 50
  localparam int unsigned QUOT_W    = 20;
  localparam int unsigned REM_W     = 32;
  localparam int unsigned PMIL_W    = 11;

  // divide by 1e9: estimate from the top 20 bits of the total times 2^50/1e9,
  // remainder from estimate * 1e9/2^9 shifted back up by 9
  localparam int unsigned HI_LSB    = TOTAL_W - ELAPSED_W;  // 30
  localparam int unsigned RECIP_SH  = 20;
  localparam int unsigned ODD_SH    = 9;
  localparam logic [RATE_W-1:0]    RECIP     = RATE_W'(1125899);   // floor(2^50 / 1e9)
  localparam logic [RATE_W-1:0]    DIV_ODD   = RATE_W'(1953125);   // 1e9 / 2^9
  localparam logic [REM_W-1:0]     FRAC_DIV  = REM_W'(1000000000);
  localparam logic [REM_W-1:0]     FRAC_DIV2 = REM_W'(2000000000);
  localparam logic [RATE_W-1:0]    RATE_MAX  = '1;
  localparam logic [ELAPSED_W-1:0] PTS_PER_SPEED = ELAPSED_W'(22500);
  localparam logic [SPEED_W-1:0]   SPEED_NORMAL  = SPEED_W'(4);

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SPEED = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_FIFO  = 2'd3;

  // tuning codes
  localparam logic [TUNE_W-1:0] TUNE_PAUSED  = 2'd0;
  localparam logic [TUNE_W-1:0] TUNE_SLOWER  = 2'd1;
  localparam logic [TUNE_W-1:0] TUNE_NOMINAL = 2'd2;
  localparam logic [TUNE_W-1:0] TUNE_FASTER  = 2'd3;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_MUL  = 11'b000_0000_0010,
    ST_ADD  = 11'b000_0000_0100,
    ST_QA   = 11'b000_0000_1000,
    ST_QB   = 11'b000_0001_0000,
    ST_QC   = 11'b000_0010_0000,
    ST_FIX  = 11'b000_0100_0000,
    ST_RA   = 11'b000_1000_0000,
    ST_RB   = 11'b001_0000_0000,
    ST_RC   = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_t;

  // buffer levels seen by the regulator
  typedef struct packed {
    logic [BLOCKS_W-1:0] used;
    logic [BLOCKS_W-1:0] free;
    logic                live;
  } level_t;

  function automatic logic [PMIL_W-1:0] permille(input logic [TUNE_W-1:0] code);
    logic [PMIL_W-1:0] p;
    case (code)
      TUNE_PAUSED: p = PMIL_W'(0);
      TUNE_SLOWER: p = PMIL_W'(995);
      TUNE_FASTER: p = PMIL_W'(1005);
      default:     p = PMIL_W'(1000);
    endcase
    return p;
  endfunction

endpackage

// File: rtl/frcr_mul.sv
// Shared registered multiplier, 29 x 20 bits.
module frcr_mul (
  input  logic                             clk,
  input  logic [frcr_pkg::RATE_W-1:0]      a,
  input  logic [frcr_pkg::ELAPSED_W-1:0]   b,
  output logic [frcr_pkg::PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= frcr_pkg::PROD_W'(a) * frcr_pkg::PROD_W'(b);
  end

endmodule

// File: rtl/frcr_div.sv
// Final step of the divide by 1e9: lifts the reciprocal estimate by up to two.
module frcr_div (
  input  logic [frcr_pkg::QUOT_W-1:0]      quot_est,
  input  logic [frcr_pkg::REM_W-1:0]       rem_est,
  output logic [frcr_pkg::QUOT_W-1:0]      quot,
  output logic [frcr_pkg::FRAC_W-1:0]      rem
);

  // estimate is never high; remainder below 3e9
  always_comb begin
    if (rem_est >= frcr_pkg::FRAC_DIV2) begin
      quot = quot_est + frcr_pkg::QUOT_W'(2);
      rem  = frcr_pkg::FRAC_W'(rem_est - frcr_pkg::FRAC_DIV2);
    end else if (rem_est >= frcr_pkg::FRAC_DIV) begin
      quot = quot_est + frcr_pkg::QUOT_W'(1);
      rem  = frcr_pkg::FRAC_W'(rem_est - frcr_pkg::FRAC_DIV);
    end else begin
      quot = quot_est;
      rem  = frcr_pkg::FRAC_W'(rem_est);
    end
  end

endmodule

// File: rtl/frcr_reg.sv
// Buffer-level regulator: picks the next tuning code.
module frcr_reg (
  input  logic [frcr_pkg::TUNE_W-1:0]  tuning,
  input  logic [frcr_pkg::SPEED_W-1:0] speed,
  input  frcr_pkg::level_t             level,
  output logic [frcr_pkg::TUNE_W-1:0]  tuning_next
);

  logic [frcr_pkg::BLOCKS_W:0] used2;
  logic [frcr_pkg::BLOCKS_W:0] free2;
  logic [frcr_pkg::BLOCKS_W:0] used_x;
  logic [frcr_pkg::BLOCKS_W:0] free_x;

  assign used_x = {1'b0, level.used};
  assign free_x = {1'b0, level.free};
  assign used2  = {level.used, 1'b0};
  assign free2  = {level.free, 1'b0};

  always_comb begin
    tuning_next = tuning;
    if (level.used == '0 && tuning != frcr_pkg::TUNE_PAUSED) begin
      tuning_next = frcr_pkg::TUNE_PAUSED;
    end else if (tuning == frcr_pkg::TUNE_PAUSED) begin
      if (used2 > free_x) tuning_next = frcr_pkg::TUNE_NOMINAL;
    end else if (speed == frcr_pkg::SPEED_NORMAL && level.live) begin
      if (used_x > free2) begin
        tuning_next = frcr_pkg::TUNE_FASTER;
      end else if (free_x > used2) begin
        tuning_next = frcr_pkg::TUNE_SLOWER;
      end else if ((tuning == frcr_pkg::TUNE_FASTER && level.free > level.used) ||
                   (tuning == frcr_pkg::TUNE_SLOWER && level.used > level.free)) begin
        tuning_next = frcr_pkg::TUNE_NOMINAL;
      end
    end else begin
      tuning_next = frcr_pkg::TUNE_NOMINAL;
    end
  end

endmodule

// File: rtl/fifo_regulated_clock_reference_core.sv
// Top level of the rate-regulated 90 kHz clock reference.
// A tick runs multiply, add, two reciprocal multiplies, remainder and correction; set speed
// and fifo check run two rate passes; load registers its result directly.
// Throughput: one transaction in flight; the next is taken the cycle after the result is
// registered, or later while the output stalls.
// Synchronous reset: timestamp 0, remainder 0, speed 0, tuning nominal, rate 0, output empty.
module fifo_regulated_clock_reference_core (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata: elapsed_us[19:0], new_speed[24:20], pts_value[72:25],
  //          used_blocks[88:73], free_blocks[104:89], realtime_mode[105], zero pad
  input  logic [111:0] s_tdata,
  // s_tuser: operation[1:0]
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: current_pts[47:0], tuning_state[49:48], zero pad
  output logic [55:0]  m_tdata
);

  // input field unpacking
  logic [frcr_pkg::ELAPSED_W-1:0] in_elapsed;
  logic [frcr_pkg::SPEED_W-1:0]   in_speed;
  logic [frcr_pkg::PTS_W-1:0]     in_pts;
  frcr_pkg::level_t               in_level;

  assign in_elapsed        = s_tdata[19:0];
  assign in_speed          = s_tdata[24:20];
  assign in_pts            = s_tdata[72:25];
  assign in_level.used     = s_tdata[88:73];
  assign in_level.free     = s_tdata[104:89];
  assign in_level.live     = s_tdata[105];

  // architectural state
  frcr_pkg::state_t               state;
  logic [frcr_pkg::PTS_W-1:0]     timestamp;
  logic [frcr_pkg::FRAC_W-1:0]    frac;
  logic [frcr_pkg::SPEED_W-1:0]   speed;
  logic [frcr_pkg::TUNE_W-1:0]    tuning;
  logic [frcr_pkg::RATE_W-1:0]    rate;
  logic [frcr_pkg::ELAPSED_W-1:0] elapsed;

  // output register
  logic [frcr_pkg::PTS_W-1:0]     out_pts;
  logic [frcr_pkg::TUNE_W-1:0]    out_tune;

  // shared multiplier
  logic [frcr_pkg::RATE_W-1:0]    mul_a;
  logic [frcr_pkg::ELAPSED_W-1:0] mul_b;
  logic [frcr_pkg::PROD_W-1:0]    mul_p;

  // divide by 1e9
  logic [frcr_pkg::TOTAL_W-1:0]   div_total;
  logic [frcr_pkg::TOTAL_W-1:0]   total;
  logic [frcr_pkg::QUOT_W-1:0]    quot_est;
  logic [frcr_pkg::REM_W-1:0]     rem_est;
  logic [frcr_pkg::QUOT_W-1:0]    div_quot;
  logic [frcr_pkg::FRAC_W-1:0]    div_rem;

  logic [frcr_pkg::TUNE_W-1:0]    tuning_next;
  logic                           in_xfer;
  logic                           out_free;

  assign s_tready = (state == frcr_pkg::ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {6'b0, out_tune, out_pts};

  // multiplier operand select: tick product, quotient estimate, estimate * 1e9/2^9,
  // speed*22500, then *permille
  always_comb begin
    unique case (state)
      frcr_pkg::ST_MUL: begin
        mul_a = rate;
        mul_b = elapsed;
      end
      frcr_pkg::ST_QA: begin
        mul_a = frcr_pkg::RECIP;
        mul_b = total[frcr_pkg::TOTAL_W-1:frcr_pkg::HI_LSB];
      end
      frcr_pkg::ST_QB: begin
        mul_a = frcr_pkg::DIV_ODD;
        mul_b = mul_p[frcr_pkg::RECIP_SH +: frcr_pkg::ELAPSED_W];
      end
      frcr_pkg::ST_RA: begin
        mul_a = frcr_pkg::RATE_W'(speed);
        mul_b = frcr_pkg::PTS_PER_SPEED;
      end
      default: begin
        mul_a = frcr_pkg::RATE_W'(mul_p[frcr_pkg::ELAPSED_W-1:0]);
        mul_b = frcr_pkg::ELAPSED_W'(frcr_pkg::permille(tuning));
      end
    endcase
  end

  frcr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // total = remainder + elapsed * rate; below 2^50
  assign div_total = frcr_pkg::TOTAL_W'(frac) + frcr_pkg::TOTAL_W'(mul_p);

  frcr_div u_div (
    .quot_est (quot_est),
    .rem_est  (rem_est),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  frcr_reg u_reg (
    .tuning      (tuning),
    .speed       (speed),
    .level       (in_level),
    .tuning_next (tuning_next)
  );

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frcr_pkg::ST_IDLE;
      timestamp <= '0;
      frac      <= '0;
      speed     <= '0;
      tuning    <= frcr_pkg::TUNE_NOMINAL;
      rate      <= '0;
    end else begin
      unique case (state)
        frcr_pkg::ST_IDLE: begin
          if (in_xfer) begin
            case (s_tuser)
              frcr_pkg::OP_TICK: begin
                state <= frcr_pkg::ST_MUL;
              end
              frcr_pkg::OP_SPEED: begin
                speed <= in_speed;
                state <= frcr_pkg::ST_RA;
              end
              frcr_pkg::OP_LOAD: begin
                timestamp <= in_pts;
                frac      <= '0;
                state     <= frcr_pkg::ST_FIN;
              end
              default: begin
                // fifo check; rate is recomputed whether or not the code moved
                tuning <= tuning_next;
                state  <= frcr_pkg::ST_RA;
              end
            endcase
          end
        end
        frcr_pkg::ST_MUL: state <= frcr_pkg::ST_ADD;
        frcr_pkg::ST_ADD: state <= frcr_pkg::ST_QA;
        frcr_pkg::ST_QA:  state <= frcr_pkg::ST_QB;
        frcr_pkg::ST_QB:  state <= frcr_pkg::ST_QC;
        frcr_pkg::ST_QC:  state <= frcr_pkg::ST_FIX;
        frcr_pkg::ST_FIX: begin
          // timestamp wraps modulo 2^48
          timestamp <= timestamp + frcr_pkg::PTS_W'(div_quot);
          frac      <= div_rem;
          state     <= frcr_pkg::ST_FIN;
        end
        frcr_pkg::ST_RA: state <= frcr_pkg::ST_RB;
        frcr_pkg::ST_RB: state <= frcr_pkg::ST_RC;
        frcr_pkg::ST_RC: begin
          // saturate at 2^29-1
          if (|mul_p[frcr_pkg::PROD_W-1:frcr_pkg::RATE_W]) begin
            rate <= frcr_pkg::RATE_MAX;
          end else begin
            rate <= mul_p[frcr_pkg::RATE_W-1:0];
          end
          state <= frcr_pkg::ST_FIN;
        end
        frcr_pkg::ST_FIN: begin
          if (out_free) state <= frcr_pkg::ST_IDLE;
        end
        default: state <= frcr_pkg::ST_IDLE;
      endcase
    end
  end

  // result valid: set when the result is registered, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == frcr_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) elapsed <= in_elapsed;
    if (state == frcr_pkg::ST_ADD) total <= div_total;
    if (state == frcr_pkg::ST_QB) quot_est <= mul_p[frcr_pkg::RECIP_SH +: frcr_pkg::QUOT_W];
    // true remainder of the estimate is below 2^32, so the low bits suffice
    if (state == frcr_pkg::ST_QC) begin
      rem_est <= total[frcr_pkg::REM_W-1:0] - (mul_p[frcr_pkg::REM_W-1:0] << frcr_pkg::ODD_SH);
    end
    if (state == frcr_pkg::ST_FIN && out_free) begin
      out_pts  <= timestamp;
      out_tune <= tuning;
    end
  end

endmodule
